// ----- hw/rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, command codes and control structs of the first-fit
// heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int ARENA_BYTES_DEF  = 65536;
    localparam int ALIGN_BYTES_DEF  = 16;
    localparam int HEADER_BYTES_DEF = 32;

    localparam int REQ_W  = 17;
    localparam int ADDR_W = 16;
    localparam int STAT_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
    localparam logic [OP_W-1:0] OP_CLR    = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 5'd2;
    localparam logic [OP_W-1:0] OP_ASTART = 5'd4;
    localparam logic [OP_W-1:0] OP_RD_G   = 5'd5;
    localparam logic [OP_W-1:0] OP_ANEXT  = 5'd6;
    localparam logic [OP_W-1:0] OP_TAKE   = 5'd7;
    localparam logic [OP_W-1:0] OP_WRN    = 5'd8;
    localparam logic [OP_W-1:0] OP_RD_X   = 5'd9;
    localparam logic [OP_W-1:0] OP_WR_XB  = 5'd10;
    localparam logic [OP_W-1:0] OP_WR_G   = 5'd11;
    localparam logic [OP_W-1:0] OP_FSTART = 5'd12;
    localparam logic [OP_W-1:0] OP_FCUR   = 5'd13;
    localparam logic [OP_W-1:0] OP_RD_B   = 5'd14;
    localparam logic [OP_W-1:0] OP_MERGEP = 5'd15;
    localparam logic [OP_W-1:0] OP_XN     = 5'd16;
    localparam logic [OP_W-1:0] OP_MERGEN = 5'd17;
    localparam logic [OP_W-1:0] OP_OUT    = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [STAT_W-1:0] st;
    } ffha_cmd_t;

    typedef struct packed {
        logic free_cmd;
        logic clr_done;
        logic bad_free;
        logic g_in;
        logic x_in;
        logic g_zero;
        logic fit;
        logic split;
        logic used_blk;
        logic rd_free;
    } ffha_stat_t;

endpackage

// ----- hw/rtl/ffha_datapath.sv -----
// ----------------------------------------------------------------------------
// ffha_datapath
// Header memory, size scaling, walk registers and result register of the
// allocator. Each cycle it carries out the one command it is given.
// ----------------------------------------------------------------------------
module ffha_datapath #(
    parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffha_pkg::ffha_cmd_t           cmd,
    output ffha_pkg::ffha_stat_t          stat,
    input  logic                          in_cmd,
    input  logic [ffha_pkg::REQ_W-1:0]    in_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0]   in_addr,
    output logic [ffha_pkg::ADDR_W-1:0]   out_addr,
    output logic [ffha_pkg::STAT_W-1:0]   out_status
);
    import ffha_pkg::*;

    localparam int NGRAN = ARENA_BYTES / ALIGN_BYTES;
    localparam int HDR_G = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int IW    = $clog2(NGRAN);
    localparam int GW    = IW + 1;
    localparam int EW    = 2 * IW + 2;
    // The alignment is a power of two, so granules come from a shift and a mask.
    localparam int RB    = $clog2(ALIGN_BYTES);

    // Entry layout: start, free, before, length (length in the low bits).
    logic [EW-1:0] mem [NGRAN];

    logic [IW-1:0]     clr_cnt_reg;
    logic [REQ_W-1:0]  dvd_reg;
    logic [RB-1:0]     rem_reg;
    logic              free_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [REQ_W-1:0]  need_reg;
    logic [GW-1:0]     g_reg;
    logic [GW-1:0]     x_reg;
    logic [IW-1:0]     y_reg;
    logic [EW-1:0]     cur_reg;
    logic [EW-1:0]     rd_q_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [STAT_W-1:0] out_status_reg;

    logic [REQ_W-1:0]  ld_val;
    logic [IW-1:0]     rd_len;
    logic [IW-1:0]     cur_len;
    logic [IW-1:0]     cur_bef;
    logic              rd_start;
    logic              rd_free;
    logic [GW-1:0]     g_next_blk;
    logic [GW-1:0]     rd_next_blk;
    logic [31:0]       res_full;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    logic [EW-1:0]     wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_idx;

    function automatic logic [EW-1:0] mk_entry(input logic st, input logic fr,
                                               input logic [IW-1:0] bef,
                                               input logic [IW-1:0] len);
        mk_entry = {st, fr, bef, len};
    endfunction

    assign rd_len   = rd_q_reg[IW-1:0];
    assign rd_start = rd_q_reg[EW-1];
    assign rd_free  = rd_q_reg[EW-2];
    assign cur_len  = cur_reg[IW-1:0];
    assign cur_bef  = cur_reg[EW-3:IW];

    assign g_next_blk  = g_reg + GW'(HDR_G) + GW'(cur_len);
    assign rd_next_blk = x_reg + GW'(HDR_G) + GW'(rd_len);

    // Byte value to split into whole granules and a remainder.
    assign ld_val = in_cmd ? REQ_W'(in_addr)
                  : ((in_bytes == '0) ? REQ_W'(1) : in_bytes);

    assign res_full = (32'(g_reg) + 32'(HDR_G)) * 32'(ALIGN_BYTES);

    always_comb begin
        stat.free_cmd = free_reg;
        stat.clr_done = (clr_cnt_reg == IW'(NGRAN - 1));
        stat.bad_free = (addr_reg == '0) || (rem_reg != '0)
                     || (32'(dvd_reg) < 32'(HDR_G))
                     || (32'(dvd_reg) >= 32'(NGRAN + HDR_G));
        stat.g_in     = (32'(g_reg) < 32'(NGRAN));
        stat.x_in     = (32'(x_reg) < 32'(NGRAN));
        stat.g_zero   = (g_reg == '0);
        stat.fit      = rd_free && (32'(rd_len) >= 32'(need_reg));
        stat.split    = (32'(rd_len) - 32'(need_reg)) >= 32'(HDR_G + 1);
        stat.used_blk = rd_start && !rd_free;
        stat.rd_free  = rd_free;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = g_reg[IW-1:0];
        wr_data = cur_reg;
        rd_en   = 1'b0;
        rd_idx  = g_reg[IW-1:0];
        case (cmd.op)
            OP_CLR: begin
                wr_en   = 1'b1;
                wr_idx  = clr_cnt_reg;
                wr_data = (clr_cnt_reg == '0)
                        ? mk_entry(1'b1, 1'b1, '0, IW'(NGRAN - HDR_G)) : '0;
            end
            OP_RD_G: rd_en = 1'b1;
            OP_RD_X: begin
                rd_en  = 1'b1;
                rd_idx = x_reg[IW-1:0];
            end
            OP_RD_B: begin
                rd_en  = 1'b1;
                rd_idx = cur_bef;
            end
            OP_WRN: begin
                wr_en   = 1'b1;
                wr_idx  = IW'(g_reg + GW'(HDR_G) + GW'(need_reg));
                wr_data = mk_entry(1'b1, 1'b1, g_reg[IW-1:0],
                              IW'(32'(cur_len) - 32'(need_reg) - 32'(HDR_G)));
            end
            OP_WR_XB: begin
                wr_en   = 1'b1;
                wr_idx  = x_reg[IW-1:0];
                wr_data = mk_entry(rd_start, rd_free, y_reg, rd_len);
            end
            OP_WR_G: wr_en = 1'b1;
            OP_MERGEP: begin
                wr_en   = 1'b1;
                wr_data = {1'b0, cur_reg[EW-2:0]};
            end
            OP_MERGEN: begin
                wr_en   = 1'b1;
                wr_idx  = x_reg[IW-1:0];
                wr_data = {1'b0, rd_q_reg[EW-2:0]};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.op == OP_CLR) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                free_reg <= in_cmd;
                addr_reg <= in_addr;
                dvd_reg  <= ld_val >> RB;
                rem_reg  <= ld_val[RB-1:0];
            end
            OP_ASTART: begin
                need_reg <= dvd_reg + REQ_W'(rem_reg != '0);
                g_reg    <= '0;
            end
            OP_ANEXT: begin
                g_reg <= g_reg + GW'(HDR_G) + GW'(rd_len);
            end
            OP_TAKE: begin
                cur_reg <= {rd_start, 1'b0, rd_q_reg[EW-3:0]};
            end
            OP_WRN: begin
                x_reg   <= g_next_blk;
                y_reg   <= IW'(g_reg + GW'(HDR_G) + GW'(need_reg));
                cur_reg <= {cur_reg[EW-1:IW], IW'(need_reg)};
            end
            OP_FSTART: begin
                g_reg <= GW'(32'(dvd_reg) - 32'(HDR_G));
            end
            OP_FCUR: begin
                cur_reg <= {rd_start, 1'b1, rd_q_reg[EW-3:0]};
            end
            OP_RD_B: begin
                x_reg <= GW'(cur_bef);
            end
            OP_MERGEP: begin
                // x holds the predecessor here; it becomes the working block.
                g_reg   <= x_reg;
                y_reg   <= x_reg[IW-1:0];
                x_reg   <= g_next_blk;
                cur_reg <= mk_entry(rd_start, rd_free, rd_q_reg[EW-3:IW],
                                    IW'(rd_len + cur_len + IW'(HDR_G)));
            end
            OP_XN: begin
                x_reg <= g_next_blk;
            end
            OP_MERGEN: begin
                x_reg   <= rd_next_blk;
                y_reg   <= g_reg[IW-1:0];
                cur_reg <= {cur_reg[EW-1:IW], IW'(cur_len + rd_len + IW'(HDR_G))};
            end
            OP_OUT: begin
                out_status_reg <= cmd.st;
                out_addr_reg   <= (!free_reg && cmd.st == ST_OK) ? res_full[ADDR_W-1:0]
                                                                 : '0;
            end
            default: begin
                free_reg <= free_reg;
            end
        endcase
    end

    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

endmodule

// ----- hw/rtl/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller of the allocator: clearing pass, decode, first-fit walk,
// split, free with coalescing, and the result handshake.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  ffha_pkg::ffha_stat_t  stat,
    output ffha_pkg::ffha_cmd_t   cmd
);
    import ffha_pkg::*;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DEC   = 5'd3;
    localparam logic [4:0] S_ARD   = 5'd4;
    localparam logic [4:0] S_ACHK  = 5'd5;
    localparam logic [4:0] S_AWRN  = 5'd6;
    localparam logic [4:0] S_ARDA  = 5'd7;
    localparam logic [4:0] S_AWRA  = 5'd8;
    localparam logic [4:0] S_AWRG  = 5'd9;
    localparam logic [4:0] S_FRDG  = 5'd10;
    localparam logic [4:0] S_FTST  = 5'd11;
    localparam logic [4:0] S_FRDP  = 5'd12;
    localparam logic [4:0] S_FTP   = 5'd13;
    localparam logic [4:0] S_FRD1  = 5'd14;
    localparam logic [4:0] S_FWR1  = 5'd15;
    localparam logic [4:0] S_FNX   = 5'd16;
    localparam logic [4:0] S_FRDN  = 5'd17;
    localparam logic [4:0] S_FTN   = 5'd18;
    localparam logic [4:0] S_FRD2  = 5'd19;
    localparam logic [4:0] S_FWR2  = 5'd20;
    localparam logic [4:0] S_FWG   = 5'd21;
    localparam logic [4:0] S_OUT   = 5'd22;

    logic [4:0]        state_reg, state_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic              m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        st_next       = st_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = OP_NOP;
        cmd.st        = st_reg;
        unique case (state_reg)
            S_CLR: begin
                cmd.op = OP_CLR;
                if (stat.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (!stat.free_cmd) begin
                    cmd.op     = OP_ASTART;
                    state_next = S_ARD;
                end else if (stat.bad_free) begin
                    st_next    = ST_IGNORED;
                    state_next = S_OUT;
                end else begin
                    cmd.op     = OP_FSTART;
                    state_next = S_FRDG;
                end
            end
            S_ARD: begin
                if (!stat.g_in) begin
                    st_next    = ST_NOSPACE;
                    state_next = S_OUT;
                end else begin
                    cmd.op     = OP_RD_G;
                    state_next = S_ACHK;
                end
            end
            S_ACHK: begin
                if (stat.fit) begin
                    cmd.op     = OP_TAKE;
                    state_next = stat.split ? S_AWRN : S_AWRG;
                end else begin
                    cmd.op     = OP_ANEXT;
                    state_next = S_ARD;
                end
            end
            S_AWRN: begin
                cmd.op     = OP_WRN;
                state_next = S_ARDA;
            end
            S_ARDA: begin
                if (stat.x_in) begin
                    cmd.op     = OP_RD_X;
                    state_next = S_AWRA;
                end else begin
                    state_next = S_AWRG;
                end
            end
            S_AWRA: begin
                cmd.op     = OP_WR_XB;
                state_next = S_AWRG;
            end
            S_AWRG: begin
                cmd.op     = OP_WR_G;
                st_next    = ST_OK;
                state_next = S_OUT;
            end
            S_FRDG: begin
                cmd.op     = OP_RD_G;
                state_next = S_FTST;
            end
            S_FTST: begin
                if (!stat.used_blk) begin
                    st_next    = ST_IGNORED;
                    state_next = S_OUT;
                end else begin
                    cmd.op     = OP_FCUR;
                    state_next = stat.g_zero ? S_FNX : S_FRDP;
                end
            end
            S_FRDP: begin
                cmd.op     = OP_RD_B;
                state_next = S_FTP;
            end
            S_FTP: begin
                if (stat.rd_free) begin
                    cmd.op     = OP_MERGEP;
                    state_next = S_FRD1;
                end else begin
                    state_next = S_FNX;
                end
            end
            S_FRD1: begin
                if (stat.x_in) begin
                    cmd.op     = OP_RD_X;
                    state_next = S_FWR1;
                end else begin
                    state_next = S_FNX;
                end
            end
            S_FWR1: begin
                cmd.op     = OP_WR_XB;
                state_next = S_FNX;
            end
            S_FNX: begin
                cmd.op     = OP_XN;
                state_next = S_FRDN;
            end
            S_FRDN: begin
                if (stat.x_in) begin
                    cmd.op     = OP_RD_X;
                    state_next = S_FTN;
                end else begin
                    state_next = S_FWG;
                end
            end
            S_FTN: begin
                if (stat.rd_free) begin
                    cmd.op     = OP_MERGEN;
                    state_next = S_FRD2;
                end else begin
                    state_next = S_FWG;
                end
            end
            S_FRD2: begin
                if (stat.x_in) begin
                    cmd.op     = OP_RD_X;
                    state_next = S_FWR2;
                end else begin
                    state_next = S_FWG;
                end
            end
            S_FWR2: begin
                cmd.op     = OP_WR_XB;
                state_next = S_FWG;
            end
            S_FWG: begin
                cmd.op     = OP_WR_G;
                st_next    = ST_OK;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = OP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            st_reg       <= ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            st_reg       <= st_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with split and coalescing over a fixed arena of
// header-prefixed blocks kept in an on-chip header memory.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   s_*      in         one command word: tuser = cmd, tdata = size / address
//   m_*      out        one result word: tdata = payload offset and status
//
// After a command word is taken, a decode state reads it and checks a free's
// address. An allocate then makes one memory read and one compare for each
// block header visited in the first-fit walk, splits the block where there is
// room, writes back, and presents the result. A free tests the block, merges
// it with a free neighbor on either side, and then presents the result.
// After reset a clearing pass writes every header entry, one per cycle
// (ARENA_BYTES / ALIGN_BYTES entries, 4096 by default), with s_tready low.
// A result word waits in the output register while m_tready is low; the
// next command word is taken meanwhile, and finishes once that word is taken.
//
module first_fit_heap_allocator #(
    parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // request_bytes [16:0], block_addr [32:17], zero fill [39:33]
    input  logic [ffha_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd [0]: 0 allocate, 1 free
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_addr [15:0], status [17:16], zero fill [23:18]
    output logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ffha_pkg::*;

    ffha_cmd_t         cmd;
    ffha_stat_t        stat;
    logic [ADDR_W-1:0] out_addr;
    logic [STAT_W-1:0] out_status;

    // The controller sequences every step; the datapath owns all storage.
    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffha_datapath #(
        .ARENA_BYTES  (ARENA_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (s_tuser),
        .in_bytes   (s_tdata[REQ_W-1:0]),
        .in_addr    (s_tdata[REQ_W+ADDR_W-1:REQ_W]),
        .out_addr   (out_addr),
        .out_status (out_status)
    );

    // The result word: offset in the low 16 bits, status above it.
    assign m_tdata = {{(M_TDATA_W - ADDR_W - STAT_W){1'b0}}, out_status, out_addr};

endmodule

// ----- hw/rtl/ffha_check.sv -----
// ----------------------------------------------------------------------------
// ffha_check
// Port-level assertions of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A command word is worked on alone: no second word the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command word taken while another is in progress");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[17:16] != 2'd3)
        else $error("undefined status code");

    // Only a successful allocate carries an offset.
    a_addr_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:16] != 2'd0 |-> m_tdata[15:0] == 16'd0)
        else $error("offset given with a failing status");

endmodule

bind first_fit_heap_allocator ffha_check u_ffha_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker
// Watches both channels of the allocator, keeps a granule-level shadow of
// the arena, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module ffha_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ffha_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              fail_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int NGRAN = ARENA_BYTES_DEF / ALIGN_BYTES_DEF;
    localparam int HDR_G = (HEADER_BYTES_DEF + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] st;
    } result_t;

    int unsigned       blen  [NGRAN];
    bit                bfree [NGRAN];
    int unsigned       bprev [NGRAN];
    bit                bstart[NGRAN];
    result_t           expected_results[$];

    function automatic int unsigned next_hdr(int unsigned g);
        return g + HDR_G + blen[g];
    endfunction

    function automatic result_t predict_alloc(logic [REQ_W-1:0] bytes);
        int unsigned need, g, spare, n, after;
        result_t r;
        need = (bytes == 0) ? 1 : (int'(bytes) + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF;
        g = 0;
        r = '{addr: '0, st: ST_NOSPACE};
        while (g < NGRAN) begin
            if (bfree[g] && blen[g] >= need) begin
                spare = blen[g] - need;
                if (spare >= HDR_G + 1) begin
                    n = g + HDR_G + need;
                    bstart[n] = 1;
                    bfree[n]  = 1;
                    blen[n]   = spare - HDR_G;
                    bprev[n]  = g;
                    after = next_hdr(n);
                    if (after < NGRAN) bprev[after] = n;
                    blen[g] = need;
                end
                bfree[g] = 0;
                r.addr = ADDR_W'((g + HDR_G) * ALIGN_BYTES_DEF);
                r.st   = ST_OK;
                return r;
            end
            g = next_hdr(g);
        end
        return r;
    endfunction

    function automatic result_t predict_free(logic [ADDR_W-1:0] addr);
        int unsigned pg, g, p, n, nn;
        result_t r;
        r = '{addr: '0, st: ST_IGNORED};
        if (addr == 0 || addr % ALIGN_BYTES_DEF != 0) return r;
        pg = addr / ALIGN_BYTES_DEF;
        if (pg < HDR_G || pg - HDR_G >= NGRAN) return r;
        g = pg - HDR_G;
        if (!bstart[g] || bfree[g]) return r;
        bfree[g] = 1;
        if (g != 0) begin
            p = bprev[g];
            if (bfree[p]) begin
                n = next_hdr(g);
                blen[p] += blen[g] + HDR_G;
                bstart[g] = 0;
                if (n < NGRAN) bprev[n] = p;
                g = p;
            end
        end
        n = next_hdr(g);
        if (n < NGRAN && bfree[n]) begin
            nn = next_hdr(n);
            blen[g] += blen[n] + HDR_G;
            bstart[n] = 0;
            if (nn < NGRAN) bprev[nn] = g;
        end
        r.st = ST_OK;
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < NGRAN; i++) begin
                blen[i] = 0; bfree[i] = 0; bprev[i] = 0; bstart[i] = 0;
            end
            blen[0] = NGRAN - HDR_G;
            bfree[0] = 1;
            bstart[0] = 1;
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser)
                    expected_results.push_back(predict_free(s_tdata[32:17]));
                else
                    expected_results.push_back(predict_alloc(s_tdata[16:0]));
            end
            if (m_tvalid && m_tready) begin
                got.addr = m_tdata[15:0];
                got.st   = m_tdata[17:16];
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected result word: addr=%h status=%0d",
                                 got.addr, got.st);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (fail_count < 10)
                            $display("Mismatch: addr exp %h got %h, status exp %0d got %0d",
                                     want.addr, got.addr, want.st, got.st);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the first-fit heap allocator: directed corner
// words, then random allocate/free traffic with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int  LIMIT_CYCLES = 20_000_000;
    localparam int  RANDOM_WORDS = 1000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    int                     fail_count;
    int                     pending_count;
    int                     cycle_count = 0;
    bit                     stim_done = 1'b0;

    // Payload offsets handed out so far, so frees can target live blocks.
    logic [ADDR_W-1:0]      live_blocks[$];

    always #4 aclk = ~aclk;

    first_fit_heap_allocator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    ffha_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Mostly short gaps, now and then a long one, and runs with none at all.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Record allocated offsets as results come back, for later frees.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tdata[17:16] == ST_OK && m_tdata[15:0] != 0)
            live_blocks.push_back(m_tdata[15:0]);
    end

    // Receiver side stalls at random, with quiet stretches now and then.
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Drive one word; the checker sees it at the accepting edge. The word
    // stays valid until the next one replaces it or a gap clears it.
    task automatic send_word(bit is_free, logic [REQ_W-1:0] bytes, logic [ADDR_W-1:0] addr);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_free;
        s_tdata  <= {7'd0, addr, bytes};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic alloc_word(logic [REQ_W-1:0] bytes);
        send_word(1'b0, bytes, ADDR_W'($urandom));
    endtask

    task automatic free_word(logic [ADDR_W-1:0] addr);
        send_word(1'b1, REQ_W'($urandom), addr);
    endtask

    // Pick a previously returned offset; it may already be free again.
    function automatic logic [ADDR_W-1:0] pick_live();
        if (live_blocks.size() == 0) return ADDR_W'(HEADER_BYTES_DEF);
        return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    endfunction

    initial begin
        int r;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed corners: zero and tiny sizes, exact fit, over-size requests,
        // bad frees of every kind, double free, and merging on both sides.
        alloc_word(17'd0);
        alloc_word(17'd1);
        alloc_word(17'd16);
        alloc_word(17'd17);
        alloc_word(17'h1FFFF);
        alloc_word(17'd65536);
        free_word(16'd0);
        free_word(16'd33);
        free_word(16'd16);
        free_word(16'hFFF0);
        free_word(16'd64);
        free_word(16'd32);
        free_word(16'd32);
        free_word(16'd112);
        free_word(16'd80);
        alloc_word(17'd65536 - 17'd32);
        free_word(16'd32);
        alloc_word(17'd65504);
        alloc_word(17'd1);
        free_word(16'd32);
        alloc_word(17'd48);
        free_word(16'hFFFF);
        free_word(16'd32);

        // Random traffic, mostly well-formed: small allocs and frees of live
        // blocks, with some large requests and stray addresses as noise.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      alloc_word(REQ_W'($urandom_range(0, 400)));
            else if (r < 45) alloc_word(REQ_W'($urandom_range(0, 17'h1FFFF)));
            else if (r < 48) alloc_word(REQ_W'($urandom_range(2000, 20000)));
            else if (r < 90) free_word(pick_live());
            else             free_word(ADDR_W'($urandom));
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES) begin
                $display("Simulation FAILED");
                $finish;
            end
            if (stim_done && pending_count == 0) begin
                repeat (200) @(posedge aclk);
                if (fail_count == 0 && pending_count == 0)
                    $display("Simulation PASSED");
                else
                    $display("Simulation FAILED");
                $finish;
            end
        end
    end
endmodule
